FILE: hdl/csv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csv_pkg
// Shared types and constants of the client session validator: field widths,
// mode and status codes, the classified command and the session table entry.
// ----------------------------------------------------------------------------
package csv_pkg;

    // Session table geometry
    localparam int SESSIONS    = 64;
    localparam int IDX_W       = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Field widths
    localparam int MODE_W      = 2;
    localparam int KEY_W       = 32;
    localparam int SEQ_W       = 32;
    localparam int STATUS_W    = 3;

    // First sequence of a fresh session
    localparam logic [SEQ_W-1:0] SEQ_START = SEQ_W'(1);

    typedef enum logic [MODE_W-1:0] {
        MODE_REGISTER   = 2'd0,
        MODE_UNREGISTER = 2'd1,
        MODE_CHECK      = 2'd2,
        MODE_QUERY      = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK            = 3'd0,
        STATUS_ZERO_ID       = 3'd1,
        STATUS_DUPLICATE     = 3'd2,
        STATUS_FULL          = 3'd3,
        STATUS_UNKNOWN       = 3'd4,
        STATUS_WRONG_ACCOUNT = 3'd5,
        STATUS_BAD_SEQ       = 3'd6
    } t_status;

    // Operation after classification by the front end
    typedef enum logic [2:0] {
        OP_ZERO_ID,
        OP_REGISTER,
        OP_UNREGISTER,
        OP_CHECK,
        OP_QUERY
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [KEY_W-1:0] client;
        logic [KEY_W-1:0] account;
        logic [SEQ_W-1:0] seq;
    } t_cmd;

    typedef struct packed {
        logic [KEY_W-1:0] client;
        logic [KEY_W-1:0] account;
        logic [SEQ_W-1:0] next_seq;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        t_status          status;
        logic [SEQ_W-1:0] seq_out;
    } t_rsp;

    typedef enum logic [2:0] {
        ENG_IDLE,
        ENG_SCAN,
        ENG_DRAIN,
        ENG_FINISH,
        ENG_RESULT
    } t_eng_state;

endpackage
`default_nettype wire

FILE: hdl/csv_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csv_req_if
// Request channel: valid/ready handshake carrying one request item.
// ----------------------------------------------------------------------------
interface csv_req_if;
    import csv_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  client_key;
    logic [KEY_W-1:0]  account_key;
    logic [SEQ_W-1:0]  request_seq;

    modport source (output valid, mode, client_key, account_key, request_seq, input ready);
    modport sink   (input valid, mode, client_key, account_key, request_seq, output ready);
endinterface
`default_nettype wire

FILE: hdl/csv_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csv_rsp_if
// Response channel: valid/ready handshake carrying one result item.
// ----------------------------------------------------------------------------
interface csv_rsp_if;
    import csv_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SEQ_W-1:0]    seq_out;

    modport source (output valid, status, seq_out, input ready);
    modport sink   (input valid, status, seq_out, output ready);
endinterface
`default_nettype wire

FILE: hdl/csv_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csv_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module csv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                                        i_clk,
    input  wire                                        i_we,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]                           i_wdata,
    input  wire                                        i_re,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

FILE: hdl/csv_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csv_front
// Accept request items, classify them into table operations and hand them
// to the command queue through a one-entry holding register.
// ----------------------------------------------------------------------------
module csv_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    csv_req_if.sink          i_req,
    input  wire              i_queue_full,
    output logic             o_push,
    output csv_pkg::t_cmd    o_cmd
);
    import csv_pkg::*;

    logic r_vld;
    logic n_vld;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic accept;

    // Take an item whenever the holding register is empty or draining
    assign o_push      = r_vld && !i_queue_full;
    assign i_req.ready = !r_vld || !i_queue_full;
    assign accept      = i_req.valid && i_req.ready;
    assign o_cmd       = r_cmd;

    // Classify the incoming item
    always_comb begin
        n_cmd.client  = i_req.client_key;
        n_cmd.account = i_req.account_key;
        n_cmd.seq     = i_req.request_seq;
        unique case (t_mode'(i_req.mode))
            MODE_REGISTER: begin
                if (i_req.client_key == '0 || i_req.account_key == '0) begin
                    n_cmd.op = OP_ZERO_ID;
                end else begin
                    n_cmd.op = OP_REGISTER;
                end
            end
            MODE_UNREGISTER: n_cmd.op = OP_UNREGISTER;
            MODE_CHECK:      n_cmd.op = OP_CHECK;
            MODE_QUERY:      n_cmd.op = OP_QUERY;
            default:         n_cmd.op = OP_QUERY;
        endcase
    end

    // Hold flag: set on accept, clear once pushed
    always_comb begin
        if (accept) begin
            n_vld = 1'b1;
        end else if (o_push) begin
            n_vld = 1'b0;
        end else begin
            n_vld = r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/csv_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csv_queue
// Short command queue that decouples the front end from the table engine.
// ----------------------------------------------------------------------------
module csv_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  wire csv_pkg::t_cmd i_cmd,
    output logic             o_full,
    input  wire              i_pop,
    output csv_pkg::t_cmd    o_cmd,
    output logic             o_empty
);
    import csv_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QCNT_W-1:0] n_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Advance pointers with wrap, track fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/csv_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csv_engine
// Carry out one classified command: unless it is a zero-id register, scan the
// session RAM one entry per cycle for the client match and the lowest free
// entry, then update the table and register the result item.
// ----------------------------------------------------------------------------
module csv_engine (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cmd_avail,
    input  wire csv_pkg::t_cmd i_cmd,
    output logic             o_cmd_pop,
    csv_rsp_if.source        o_rsp
);
    import csv_pkg::*;

    t_eng_state        r_state;
    t_eng_state        n_state;
    t_cmd              r_cmd;
    t_cmd              n_cmd;
    logic [IDX_W-1:0]  r_rd_idx;
    logic [IDX_W-1:0]  n_rd_idx;
    logic              r_cmp_vld;
    logic              n_cmp_vld;
    logic [IDX_W-1:0]  r_cmp_idx;
    logic [IDX_W-1:0]  n_cmp_idx;
    logic              r_hit;
    logic              n_hit;
    logic [IDX_W-1:0]  r_hit_idx;
    logic [IDX_W-1:0]  n_hit_idx;
    t_entry            r_hit_entry;
    t_entry            n_hit_entry;
    logic              r_free;
    logic              n_free;
    logic [IDX_W-1:0]  r_free_idx;
    logic [IDX_W-1:0]  n_free_idx;
    logic [SESSIONS-1:0] r_valid;
    logic [SESSIONS-1:0] n_valid;
    t_rsp              r_res;
    t_rsp              n_res;
    logic              r_out_vld;
    logic              n_out_vld;
    t_rsp              r_out;
    logic              out_load;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    t_entry            ram_wdata;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata_raw;
    t_entry            ram_rdata;

    csv_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SESSIONS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata_raw)
    );

    assign ram_rdata = t_entry'(ram_rdata_raw);

    // Sequencer and table datapath
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_rd_idx    = r_rd_idx;
        n_cmp_vld   = 1'b0;
        n_cmp_idx   = r_rd_idx;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_hit_entry = r_hit_entry;
        n_free      = r_free;
        n_free_idx  = r_free_idx;
        n_valid     = r_valid;
        n_res       = r_res;
        o_cmd_pop   = 1'b0;
        out_load    = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_free_idx;
        ram_wdata   = '{client: r_cmd.client, account: r_cmd.account, next_seq: SEQ_START};
        ram_re      = 1'b0;
        ram_raddr   = r_rd_idx;

        // Compare the entry read in the previous cycle
        if (r_cmp_vld) begin
            if (r_valid[r_cmp_idx] && ram_rdata.client == r_cmd.client && !r_hit) begin
                n_hit       = 1'b1;
                n_hit_idx   = r_cmp_idx;
                n_hit_entry = ram_rdata;
            end
            if (!r_valid[r_cmp_idx] && !r_free) begin
                n_free     = 1'b1;
                n_free_idx = r_cmp_idx;
            end
        end

        unique case (r_state)
            ENG_IDLE: begin
                if (i_cmd_avail) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_rd_idx  = '0;
                    n_hit     = 1'b0;
                    n_free    = 1'b0;
                    if (i_cmd.op == OP_ZERO_ID) begin
                        n_res   = '{status: STATUS_ZERO_ID, seq_out: '0};
                        n_state = ENG_RESULT;
                    end else begin
                        n_state = ENG_SCAN;
                    end
                end
            end
            ENG_SCAN: begin
                ram_re    = 1'b1;
                n_cmp_vld = 1'b1;
                n_cmp_idx = r_rd_idx;
                if (r_rd_idx == IDX_W'(SESSIONS - 1)) begin
                    n_state = ENG_DRAIN;
                end else begin
                    n_rd_idx = r_rd_idx + 1'b1;
                end
            end
            ENG_DRAIN: begin
                // last compare lands this cycle
                n_state = ENG_FINISH;
            end
            ENG_FINISH: begin
                n_res   = '{status: STATUS_OK, seq_out: '0};
                n_state = ENG_RESULT;
                unique case (r_cmd.op)
                    OP_REGISTER: begin
                        if (r_hit) begin
                            n_res.status = STATUS_DUPLICATE;
                        end else if (!r_free) begin
                            n_res.status = STATUS_FULL;
                        end else begin
                            ram_we              = 1'b1;
                            ram_waddr           = r_free_idx;
                            n_valid[r_free_idx] = 1'b1;
                        end
                    end
                    OP_UNREGISTER: begin
                        if (!r_hit) begin
                            n_res.status = STATUS_UNKNOWN;
                        end else begin
                            n_valid[r_hit_idx] = 1'b0;
                        end
                    end
                    OP_CHECK: begin
                        priority if (!r_hit) begin
                            n_res.status = STATUS_UNKNOWN;
                        end else if (r_hit_entry.account != r_cmd.account) begin
                            n_res.status = STATUS_WRONG_ACCOUNT;
                        end else if (r_hit_entry.next_seq != r_cmd.seq) begin
                            n_res.status = STATUS_BAD_SEQ;
                        end else begin
                            ram_we             = 1'b1;
                            ram_waddr          = r_hit_idx;
                            ram_wdata          = r_hit_entry;
                            ram_wdata.next_seq = r_hit_entry.next_seq + SEQ_W'(1);
                        end
                    end
                    OP_QUERY: begin
                        if (!r_hit) begin
                            n_res.status = STATUS_UNKNOWN;
                        end else begin
                            n_res.seq_out = r_hit_entry.next_seq;
                        end
                    end
                    default: begin
                        n_res.status = STATUS_ZERO_ID;
                    end
                endcase
            end
            ENG_RESULT: begin
                if (!r_out_vld || o_rsp.ready) begin
                    out_load = 1'b1;
                    n_state  = ENG_IDLE;
                end
            end
            default: begin
                n_state = ENG_IDLE;
            end
        endcase
    end

    // Output register: load a finished result, drop it once taken
    always_comb begin
        if (out_load) begin
            n_out_vld = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    assign o_rsp.valid   = r_out_vld;
    assign o_rsp.status  = r_out.status;
    assign o_rsp.seq_out = r_out.seq_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ENG_IDLE;
            r_cmp_vld <= 1'b0;
            r_valid   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= n_cmp_vld;
            r_valid   <= n_valid;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_rd_idx    <= n_rd_idx;
        r_cmp_idx   <= n_cmp_idx;
        r_hit       <= n_hit;
        r_hit_idx   <= n_hit_idx;
        r_hit_entry <= n_hit_entry;
        r_free      <= n_free;
        r_free_idx  <= n_free_idx;
        r_res       <= n_res;
        if (out_load) begin
            r_out <= r_res;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/client_session_validator.sv
`default_nettype none
// A register with a zero id skips the scan. Every other item is served by a
//   linear scan of the session RAM through its single read port, one entry per
//   cycle. The engine carries out one item at a time and takes the next from
//   the queue only after the last result has been loaded into the output register.
// Reset: synchronous, active low; empties all sessions, queue and output.
// ----------------------------------------------------------------------------
// client_session_validator
// Session table for order-entry clients: register, unregister, authorize a
// request by account and sequence, and query the next expected sequence.
// ----------------------------------------------------------------------------
module client_session_validator (
    input  wire       i_clk,
    input  wire       i_rst_n,
    csv_req_if.sink   i_req,
    csv_rsp_if.source o_rsp
);
    import csv_pkg::*;

    logic queue_full;
    logic queue_empty;
    logic push;
    logic pop;
    t_cmd front_cmd;
    t_cmd queue_cmd;

    csv_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_cmd        (front_cmd)
    );

    csv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_cmd   (queue_cmd),
        .o_empty (queue_empty)
    );

    csv_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_avail (!queue_empty),
        .i_cmd       (queue_cmd),
        .o_cmd_pop   (pop),
        .o_rsp       (o_rsp)
    );

endmodule
`default_nettype wire

FILE: hdl/csv_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csv_checker
// Port-level checks of the session validator: result count against
// accepted items, result field consistency and output hold under stall.
// ----------------------------------------------------------------------------
module csv_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_req_valid,
    input wire        i_req_ready,
    input wire        i_rsp_valid,
    input wire        i_rsp_ready,
    input wire [2:0]  i_rsp_status,
    input wire [31:0] i_rsp_seq_out
);
    import csv_pkg::*;

    logic [3:0] r_outstanding;
    logic [3:0] n_outstanding;
    logic       req_acc;
    logic       rsp_acc;

    assign req_acc = i_req_valid && i_req_ready;
    assign rsp_acc = i_rsp_valid && i_rsp_ready;

    // Count items accepted but not yet answered
    always_comb begin
        n_outstanding = r_outstanding;
        if (req_acc && !rsp_acc) begin
            n_outstanding = r_outstanding + 1'b1;
        end else if (rsp_acc && !req_acc) begin
            n_outstanding = r_outstanding - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
        end else begin
            r_outstanding <= n_outstanding;
        end
    end

    // No result without an item waiting for it
    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> r_outstanding != '0)
        else $error("result shown with no item outstanding");

    // Sequence is reported only on success
    a_seq_only_on_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_status != STATUS_OK) |-> i_rsp_seq_out == '0)
        else $error("nonzero sequence on a failed item");

    // Output empty right after reset
    a_reset_clears_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_rsp_valid)
        else $error("result valid right after reset");

    // Stalled result holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_seq_out)))
        else $error("stalled result changed");

endmodule

bind client_session_validator csv_checker u_csv_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_status  (o_rsp.status),
    .i_rsp_seq_out (o_rsp.seq_out)
);
`default_nettype wire
